// File: hw/rtl/mmhp_pkg.sv
// ----------------------------------------------------------------------------
// mmhp_pkg - shared types and constants of the min/max height pyramid
// command and status codes, field widths and the level base helper
// ----------------------------------------------------------------------------
`default_nettype none

package mmhp_pkg;

	// field widths of the stream beats
	localparam int CMD_W    = 2;
	localparam int SX_W     = 7;
	localparam int HEIGHT_W = 16;
	localparam int QLVL_W   = 3;
	localparam int QPOS_W   = 6;
	localparam int STS_W    = 2;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_NOT_BUILT = 2'd1;
	localparam logic [STS_W-1:0] STS_RANGE     = 2'd2;
	localparam logic [STS_W-1:0] STS_BUILT     = 2'd3;

	// status of the build sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} bld_sts_t;

	// first pyramid entry of a level, levels stored finest first
	function automatic int level_base(input int seg_log2, input int lvl);
		int b;
		b = 0;
		for (int k = 0; k < lvl; k++) begin
			b = b + (1 << (2 * (seg_log2 - k)));
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmhp_ram.sv
// ----------------------------------------------------------------------------
// mmhp_ram - simple dual port synchronous memory
// one write port, one read port with registered data held between reads
// ----------------------------------------------------------------------------
`default_nettype none

module mmhp_ram #(
	parameter int DEPTH = 4225,
	parameter int WIDTH = 16,
	parameter int AW    = 13
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/mmhp_build.sv
// ----------------------------------------------------------------------------
// mmhp_build - pyramid build sequencer
// walks every node level by level, reads four children, writes min/max back
// ----------------------------------------------------------------------------
`default_nettype none

module mmhp_build #(
	parameter int SEGMENT_LOG2 = 6,
	parameter int HAW          = 13,
	parameter int PAW          = 13,
	parameter int LVW          = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               h_re,
	output logic      [HAW-1:0]                h_raddr,
	input  wire logic [mmhp_pkg::HEIGHT_W-1:0] h_rdata,
	output logic                               p_re,
	output logic      [PAW-1:0]                p_raddr,
	input  wire logic [2*mmhp_pkg::HEIGHT_W-1:0] p_rdata,
	output logic                               p_we,
	output logic      [PAW-1:0]                p_waddr,
	output logic      [2*mmhp_pkg::HEIGHT_W-1:0] p_wdata,
	output logic      [mmhp_pkg::HEIGHT_W-1:0] root_min,
	output logic      [mmhp_pkg::HEIGHT_W-1:0] root_max,
	output mmhp_pkg::bld_sts_t                 sts
);

	localparam int S      = SEGMENT_LOG2;
	localparam int PDEPTH = ((1 << (2 * (S + 1))) - 1) / 3;
	localparam int HW     = mmhp_pkg::HEIGHT_W;
	localparam logic [1:0] PH_LAST = 2'd3;

	logic [PAW-1:0] lvl_base [2**LVW];

	for (genvar g = 0; g < 2**LVW; g++) begin : g_base
		if (g <= S) begin : g_used
			assign lvl_base[g] = PAW'(mmhp_pkg::level_base(S, g));
		end else begin : g_unused
			assign lvl_base[g] = '0;
		end
	end

	// walk counters
	logic [LVW-1:0] lvl_q;
	logic [S-1:0]   z_q;
	logic [S-1:0]   x_q;
	logic [1:0]     ph_q;
	logic           iss_q;
	logic [PAW-1:0] wr_addr_q;

	// read return stage
	logic           v_s1;
	logic [1:0]     ph_s1;
	logic           lvl0_s1;
	logic           fin_s1;

	logic [HW-1:0]  acc_min_q;
	logic [HW-1:0]  acc_max_q;
	logic           done_q;
	logic [HW-1:0]  root_min_q;
	logic [HW-1:0]  root_max_q;

	logic [S-1:0]   lim;
	logic [S:0]     cz;
	logic [S:0]     cx;
	logic [S:0]     hz;
	logic [S:0]     hx;
	logic [LVW-1:0] lm1;
	logic [LVW-1:0] csh;
	logic           node_end;
	logic [HW-1:0]  d_min;
	logic [HW-1:0]  d_max;
	logic [HW-1:0]  n_min;
	logic [HW-1:0]  n_max;
	logic           first;

	assign lim      = {S{1'b1}} >> lvl_q;
	assign cz       = {z_q, ph_q[0]};
	assign cx       = {x_q, ph_q[1]};
	assign hz       = {1'b0, z_q} + (S+1)'(ph_q[0]);
	assign hx       = {1'b0, x_q} + (S+1)'(ph_q[1]);
	assign lm1      = lvl_q - LVW'(1);
	assign csh      = LVW'(S) - lm1;
	assign node_end = (ph_q == PH_LAST);

	// level 0 reads four corner samples, higher levels four child nodes
	assign h_re    = iss_q && (lvl_q == '0);
	assign h_raddr = (HAW'(hz) << S) + HAW'(hz) + HAW'(hx);
	assign p_re    = iss_q && (lvl_q != '0);
	assign p_raddr = lvl_base[lm1] + (PAW'(cz) << csh) + PAW'(cx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q     <= '0;
			z_q       <= '0;
			x_q       <= '0;
			ph_q      <= '0;
			iss_q     <= 1'b0;
			wr_addr_q <= '0;
			v_s1      <= 1'b0;
			ph_s1     <= '0;
			lvl0_s1   <= 1'b0;
			fin_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			v_s1    <= iss_q;
			ph_s1   <= ph_q;
			lvl0_s1 <= (lvl_q == '0);
			fin_s1  <= node_end && (lvl_q == LVW'(S));
			done_q  <= v_s1 && (ph_s1 == PH_LAST) && fin_s1;
			if (p_we) begin
				wr_addr_q <= wr_addr_q + PAW'(1);
			end
			if (start) begin
				lvl_q     <= '0;
				z_q       <= '0;
				x_q       <= '0;
				ph_q      <= '0;
				iss_q     <= 1'b1;
				wr_addr_q <= '0;
			end else if (iss_q) begin
				ph_q <= ph_q + 2'd1;
				if (node_end) begin
					if (x_q == lim) begin
						x_q <= '0;
						if (z_q == lim) begin
							z_q <= '0;
							if (lvl_q == LVW'(S)) begin
								iss_q <= 1'b0;
							end else begin
								lvl_q <= lvl_q + LVW'(1);
							end
						end else begin
							z_q <= z_q + S'(1);
						end
					end else begin
						x_q <= x_q + S'(1);
					end
				end
			end
		end
	end

	// fold the returning corner sample or child node into the running min/max
	assign d_min = lvl0_s1 ? h_rdata : p_rdata[HW-1:0];
	assign d_max = lvl0_s1 ? h_rdata : p_rdata[2*HW-1:HW];
	assign first = (ph_s1 == 2'd0);
	assign n_min = (first || (d_min < acc_min_q)) ? d_min : acc_min_q;
	assign n_max = (first || (d_max > acc_max_q)) ? d_max : acc_max_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_min_q <= n_min;
			acc_max_q <= n_max;
		end
		if (v_s1 && (ph_s1 == PH_LAST) && fin_s1) begin
			root_min_q <= n_min;
			root_max_q <= n_max;
		end
	end

	// nodes are finished in storage order, so the write address just counts
	assign p_we    = v_s1 && (ph_s1 == PH_LAST);
	assign p_waddr = wr_addr_q;
	assign p_wdata = {n_max, n_min};

	assign root_min = root_min_q;
	assign root_max = root_max_q;
	assign sts.busy = iss_q | v_s1;
	assign sts.done = done_q;

`ifndef SYNTHESIS
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(p_re && p_we) |-> (p_raddr != p_waddr))
		else $error("pyramid read and write hit the same entry");

	a_wr_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		p_we |-> (wr_addr_q <= PAW'(PDEPTH - 1)))
		else $error("pyramid write beyond the last node");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/min_max_height_pyramid_core.sv
// ----------------------------------------------------------------------------
// min_max_height_pyramid_core - min/max pyramid over a square height grid
// sample writes, a pyramid build and node queries on one command stream
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tuser: command; tdata: sample x/z/height, query level/x/z
//  m_*     | out | tuser: status; tdata: node min, node max
//
//  a sample write is done at the accept; a query is accepted, then answered from the memory read
//  a build loads its result once the build sequencer is done:
//    each node reads its four children through the single read
//    port of the height or pyramid memory
//  no clearing pass after reset: both memories are undefined until written
//  results sit in an output register; writes are still taken while it is
//    full, a query or build waits there until the register frees up
//
`default_nettype none

module min_max_height_pyramid_core #(
	parameter int SEGMENT_LOG2 = 6
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// sample_x[6:0], sample_z[13:7], sample_height[29:14], query_level[32:30],
	// query_x[38:33], query_z[44:39], zero fill[47:45]
	input  wire logic [mmhp_pkg::S_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  wire logic [mmhp_pkg::CMD_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// node_min[15:0], node_max[31:16]
	output logic      [mmhp_pkg::M_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic      [mmhp_pkg::STS_W-1:0]     m_tuser
);

	localparam int S      = SEGMENT_LOG2;
	localparam int SEG    = 1 << S;
	localparam int VERT   = SEG + 1;
	localparam int HDEPTH = VERT * VERT;
	localparam int PDEPTH = ((1 << (2 * (S + 1))) - 1) / 3;
	localparam int HAW    = $clog2(HDEPTH);
	localparam int PAW    = $clog2(PDEPTH);
	localparam int LVW    = $clog2(S + 1);
	localparam int HW     = mmhp_pkg::HEIGHT_W;
	localparam int CW     = S + 8;
	localparam int CQ     = LVW + 3;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_QRSP  = 2'd1;
	localparam logic [1:0] ST_BUILD = 2'd2;
	localparam logic [1:0] ST_BRES  = 2'd3;

	// input beat fields
	logic [mmhp_pkg::CMD_W-1:0]   command;
	logic [mmhp_pkg::SX_W-1:0]    sample_x;
	logic [mmhp_pkg::SX_W-1:0]    sample_z;
	logic [HW-1:0]                sample_height;
	logic [mmhp_pkg::QLVL_W-1:0]  query_level;
	logic [mmhp_pkg::QPOS_W-1:0]  query_x;
	logic [mmhp_pkg::QPOS_W-1:0]  query_z;

	assign command       = s_tuser;
	assign sample_x      = s_tdata[6:0];
	assign sample_z      = s_tdata[13:7];
	assign sample_height = s_tdata[29:14];
	assign query_level   = s_tdata[32:30];
	assign query_x       = s_tdata[38:33];
	assign query_z       = s_tdata[44:39];

	logic [1:0]                state_q;
	logic                      pyr_valid_q;
	logic [mmhp_pkg::STS_W-1:0] qsts_s1;
	logic                      m_valid_q;
	logic [mmhp_pkg::M_DATA_W-1:0] m_data_q;
	logic [mmhp_pkg::STS_W-1:0] m_user_q;

	logic                      s_acc;
	logic                      wr_ok;
	logic                      lvl_ok;
	logic [LVW-1:0]            lv_idx;
	logic [LVW-1:0]            qsh;
	logic                      pos_ok;
	logic [mmhp_pkg::STS_W-1:0] qsts;
	logic [PAW-1:0]            q_addr;
	logic                      q_re;
	logic                      out_free;
	logic                      m_load;
	logic [mmhp_pkg::M_DATA_W-1:0] m_data_d;
	logic [mmhp_pkg::STS_W-1:0] m_user_d;
	logic                      bld_start;

	// memory ports
	logic                      h_we;
	logic [HAW-1:0]            h_waddr;
	logic                      h_re;
	logic [HAW-1:0]            h_raddr;
	logic [HW-1:0]             h_rdata;
	logic                      b_p_re;
	logic [PAW-1:0]            b_p_raddr;
	logic                      p_re;
	logic [PAW-1:0]            p_raddr;
	logic [2*HW-1:0]           p_rdata;
	logic                      p_we;
	logic [PAW-1:0]            p_waddr;
	logic [2*HW-1:0]           p_wdata;
	logic [HW-1:0]             root_min;
	logic [HW-1:0]             root_max;
	mmhp_pkg::bld_sts_t        bld_sts;

	logic [PAW-1:0]            lvl_base [2**LVW];

	for (genvar g = 0; g < 2**LVW; g++) begin : g_base
		if (g <= S) begin : g_used
			assign lvl_base[g] = PAW'(mmhp_pkg::level_base(S, g));
		end else begin : g_unused
			assign lvl_base[g] = '0;
		end
	end

	// one item at a time; the build sequencer owns both memories while busy
	assign s_tready = (state_q == ST_IDLE) && !bld_sts.busy;
	assign s_acc    = s_tvalid && s_tready;

	// sample write: vertex index is z * (SEG + 1) + x
	assign wr_ok   = (CW'(sample_x) <= CW'(SEG)) && (CW'(sample_z) <= CW'(SEG));
	assign h_we    = s_acc && (command == mmhp_pkg::CMD_WRITE) && wr_ok;
	assign h_waddr = (HAW'(sample_z) << S) + HAW'(sample_z) + HAW'(sample_x);

	// query check: not built wins over out of range
	assign lvl_ok = (CQ'(query_level) <= CQ'(S));
	assign lv_idx = LVW'(query_level);
	assign qsh    = LVW'(S) - lv_idx;
	assign pos_ok = ((query_x >> qsh) == '0) && ((query_z >> qsh) == '0);

	always_comb begin
		priority if (!pyr_valid_q) begin
			qsts = mmhp_pkg::STS_NOT_BUILT;
		end else if (!lvl_ok || !pos_ok) begin
			qsts = mmhp_pkg::STS_RANGE;
		end else begin
			qsts = mmhp_pkg::STS_OK;
		end
	end

	// node address: level base + z * nodes per row + x
	assign q_addr = lvl_base[lv_idx] + (PAW'(query_z) << qsh) + PAW'(query_x);
	assign q_re   = s_acc && (command == mmhp_pkg::CMD_QUERY) && (qsts == mmhp_pkg::STS_OK);

	assign p_re    = (state_q == ST_BUILD) ? b_p_re : q_re;
	assign p_raddr = (state_q == ST_BUILD) ? b_p_raddr : q_addr;

	assign bld_start = s_acc && (command == mmhp_pkg::CMD_BUILD);

	// output register, reloaded in the cycle it is taken
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		m_load   = 1'b0;
		m_data_d = '0;
		m_user_d = mmhp_pkg::STS_OK;
		unique case (state_q)
			ST_QRSP: begin
				m_load   = out_free;
				m_user_d = qsts_s1;
				if (qsts_s1 == mmhp_pkg::STS_OK) begin
					m_data_d = p_rdata;
				end
			end
			ST_BRES: begin
				m_load   = out_free;
				m_user_d = mmhp_pkg::STS_BUILT;
				m_data_d = {root_max, root_min};
			end
			default: begin
				m_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pyr_valid_q <= 1'b0;
			qsts_s1     <= mmhp_pkg::STS_OK;
			m_valid_q   <= 1'b0;
		end else begin
			if (m_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (command)
							mmhp_pkg::CMD_WRITE: begin
								if (wr_ok) begin
									pyr_valid_q <= 1'b0;
								end
							end
							mmhp_pkg::CMD_BUILD: begin
								state_q <= ST_BUILD;
							end
							mmhp_pkg::CMD_QUERY: begin
								qsts_s1 <= qsts;
								state_q <= ST_QRSP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_QRSP: begin
					if (m_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BUILD: begin
					if (bld_sts.done) begin
						pyr_valid_q <= 1'b1;
						state_q     <= ST_BRES;
					end
				end
				ST_BRES: begin
					if (m_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (m_load) begin
			m_data_q <= m_data_d;
			m_user_q <= m_user_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// vertex samples
	mmhp_ram #(
		.DEPTH (HDEPTH),
		.WIDTH (HW),
		.AW    (HAW)
	) u_height_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (sample_height),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// all pyramid levels, min in the low half, max in the high half
	mmhp_ram #(
		.DEPTH (PDEPTH),
		.WIDTH (2 * HW),
		.AW    (PAW)
	) u_pyramid_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	mmhp_build #(
		.SEGMENT_LOG2 (S),
		.HAW          (HAW),
		.PAW          (PAW),
		.LVW          (LVW)
	) u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (bld_start),
		.h_re     (h_re),
		.h_raddr  (h_raddr),
		.h_rdata  (h_rdata),
		.p_re     (b_p_re),
		.p_raddr  (b_p_raddr),
		.p_rdata  (p_rdata),
		.p_we     (p_we),
		.p_waddr  (p_waddr),
		.p_wdata  (p_wdata),
		.root_min (root_min),
		.root_max (root_max),
		.sts      (bld_sts)
	);

`ifndef SYNTHESIS
	a_write_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (command == mmhp_pkg::CMD_WRITE) && wr_ok) |=> !pyr_valid_q)
		else $error("pyramid still marked built after a sample write");

	a_busy_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		bld_sts.busy |-> (state_q == ST_BUILD))
		else $error("build sequencer running outside the build state");

	a_ok_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_load && (m_user_d == mmhp_pkg::STS_OK)) |-> pyr_valid_q)
		else $error("query answered from a pyramid that is not built");
`endif

endmodule

`default_nettype wire
